/* hw/rtl/rlr_pkg.sv */
// Shared types, constants and the hash function of the recursive lock registry.
package rlr_pkg;

   // Table size; a power of two so that wrap and hash reduce to masking.
   localparam int TABLE_ENTRIES = 16384;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int SLOT_W        = 14;
   localparam int KEY_W         = 64;
   localparam int TID_W         = 64;
   localparam int DEPTH_W       = 32;

   localparam logic [KEY_W-1:0]   KEY_EMPTY = KEY_W'(0);
   localparam logic [KEY_W-1:0]   KEY_TOMB  = KEY_W'(1);
   localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;
   localparam logic [63:0]        HASH_MULT = 64'h9E37_79B9_7F4A_7C15;

   typedef logic [IDX_W-1:0] idx_type;

   typedef enum logic [1:0] {
      MODE_INIT   = 2'd0,
      MODE_ENTER  = 2'd1,
      MODE_LEAVE  = 2'd2,
      MODE_DELETE = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      STAT_OK      = 3'd0,
      STAT_BUSY    = 3'd1,
      STAT_NOSLOT  = 3'd2,
      STAT_FAULT   = 3'd3,
      STAT_INVALID = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ISSUE,
      ST_PROBE,
      ST_APPLY
   } state_type;

   // One table slot as stored in memory.
   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic               held;
      logic [TID_W-1:0]   owner;
      logic [DEPTH_W-1:0] depth;
   } entry_type;

   // Located entry handed to the update logic.
   typedef struct packed {
      mode_type           mode;
      logic [TID_W-1:0]   tid;
      logic               invalid;
      logic               found;
      logic               created;
      idx_type            slot;
      entry_type          entry;
   } upd_in_type;

   // Write-back and result from the update logic.
   typedef struct packed {
      logic               we;
      entry_type          entry;
      status_type         status;
      logic [DEPTH_W-1:0] depth;
      logic [SLOT_W-1:0]  slot_index;
   } upd_out_type;

   // Home slot: only the low index bits of the 64-bit product matter,
   // so only key bits 4 up to 17 and the low index bits of HASH_MULT enter the multiply.
   function automatic idx_type home_slot(input logic [KEY_W-1:0] key);
      logic [IDX_W-1:0]   a;
      logic [2*IDX_W-1:0] prod;
      a    = key[4 +: IDX_W];
      prod = a * HASH_MULT[IDX_W-1:0];
      return prod[IDX_W-1:0];
   endfunction

endpackage

/* hw/rtl/rlr_if.sv */
// Request and response channel interfaces of the recursive lock registry.
interface rlr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [63:0] lock_key;
   logic [63:0] thread_id;

   modport source (output valid, output mode, output lock_key, output thread_id,
                   input ready);
   modport sink   (input valid, input mode, input lock_key, input thread_id,
                   output ready);
endinterface

interface rlr_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] nesting_depth;
   logic [13:0] slot_index;

   modport source (output valid, output status, output nesting_depth,
                   output slot_index, input ready);
   modport sink   (input valid, input status, input nesting_depth,
                   input slot_index, output ready);
endinterface

/* hw/rtl/rlr_ram.sv */
// Generic simple dual-port RAM with a registered read port.
module rlr_ram #(
   parameter int DEPTH = 16384,
   parameter int WIDTH = 161
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/rlr_update.sv */
// Per-mode update of a located slot: new slot contents and the result beat.
module rlr_update (
   input  rlr_pkg::upd_in_type  upd_in,
   output rlr_pkg::upd_out_type upd_out
);

   rlr_pkg::entry_type ent;
   rlr_pkg::entry_type nxt;
   logic [rlr_pkg::DEPTH_W-1:0] dec;

   always_comb begin
      ent = upd_in.entry;
      nxt = ent;
      dec = ent.depth - rlr_pkg::DEPTH_W'(1);
      upd_out.we         = upd_in.created;
      upd_out.status     = rlr_pkg::STAT_OK;
      upd_out.depth      = '0;
      upd_out.slot_index = upd_in.found ? rlr_pkg::SLOT_W'(upd_in.slot) : '0;

      if (upd_in.invalid) begin
         upd_out.status     = rlr_pkg::STAT_INVALID;
         upd_out.slot_index = '0;
         upd_out.we         = 1'b0;
      end else begin
         case (upd_in.mode)
            rlr_pkg::MODE_INIT: begin
               if (!upd_in.found) begin
                  upd_out.status = rlr_pkg::STAT_NOSLOT;
               end else begin
                  upd_out.depth = ent.depth;
               end
            end
            rlr_pkg::MODE_ENTER: begin
               if (!upd_in.found) begin
                  upd_out.status = rlr_pkg::STAT_NOSLOT;
               end else if (!ent.held) begin
                  nxt.held   = 1'b1;
                  nxt.owner  = upd_in.tid;
                  nxt.depth  = rlr_pkg::DEPTH_W'(1);
                  upd_out.we = 1'b1;
               end else if (ent.owner == upd_in.tid) begin
                  // saturate the recursion count
                  if (ent.depth != rlr_pkg::DEPTH_MAX) begin
                     nxt.depth  = ent.depth + rlr_pkg::DEPTH_W'(1);
                     upd_out.we = 1'b1;
                  end
               end else begin
                  upd_out.status = rlr_pkg::STAT_BUSY;
               end
               upd_out.depth = nxt.depth;
            end
            rlr_pkg::MODE_LEAVE: begin
               if (!upd_in.found) begin
                  upd_out.status = rlr_pkg::STAT_FAULT;
               end else if (!ent.held || ent.owner != upd_in.tid || ent.depth == '0) begin
                  upd_out.status = rlr_pkg::STAT_FAULT;
                  upd_out.depth  = ent.depth;
               end else begin
                  nxt.depth  = dec;
                  upd_out.we = 1'b1;
                  if (dec == '0) begin
                     nxt.held  = 1'b0;
                     nxt.owner = '0;
                     nxt.key   = rlr_pkg::KEY_TOMB;
                  end
                  upd_out.depth = dec;
               end
            end
            rlr_pkg::MODE_DELETE: begin
               if (upd_in.found) begin
                  if (ent.held) begin
                     upd_out.status = rlr_pkg::STAT_BUSY;
                     upd_out.depth  = ent.depth;
                  end else begin
                     nxt.key    = rlr_pkg::KEY_TOMB;
                     nxt.owner  = '0;
                     nxt.depth  = '0;
                     upd_out.we = 1'b1;
                  end
               end
            end
            default: begin
               upd_out.status = rlr_pkg::STAT_FAULT;
            end
         endcase
      end
      upd_out.entry = nxt;
   end

endmodule

/* hw/rtl/recursive_lock_registry_unit.sv */
// Top level of the recursive lock registry: probe sequencer, slot memory, result register.
//
//   channel | dir | beat fields                          | handshake
//   --------+-----+--------------------------------------+-------------
//   req     | in  | mode, lock_key, thread_id            | valid/ready
//   rsp     | out | status, nesting_depth, slot_index    | valid/ready
//
// Steps: an item goes from IDLE through ISSUE and PROBE to APPLY; PROBE reads P slots, P the slots probed
//   (1 for a hit or empty home slot, up to TABLE_ENTRIES); the one read port probes one slot per cycle. A
//   reserved key skips the probe and goes from IDLE straight to APPLY.
// Reset: a clearing pass writes all TABLE_ENTRIES slots empty
//   with req.ready low.
// Stalls: a waiting rsp beat holds the next item in APPLY with its write-back; probing is not held.
module recursive_lock_registry_unit (
   input  logic            clock,
   input  logic            reset,
   rlr_req_if.sink         req,
   rlr_rsp_if.source       rsp
);

   localparam int ENT_W = $bits(rlr_pkg::entry_type);

   // sequencer state
   rlr_pkg::state_type state_ff, state_in;
   rlr_pkg::idx_type   clr_cnt_ff, clr_cnt_in;

   // item under work
   rlr_pkg::mode_type            mode_ff, mode_in;
   logic [rlr_pkg::KEY_W-1:0]    key_ff, key_in;
   logic [rlr_pkg::TID_W-1:0]    tid_ff, tid_in;
   logic                         invalid_ff, invalid_in;
   rlr_pkg::idx_type             cur_ff, cur_in;
   rlr_pkg::idx_type             cnt_ff, cnt_in;
   logic                         tomb_vld_ff, tomb_vld_in;
   rlr_pkg::idx_type             tomb_slot_ff, tomb_slot_in;
   logic                         found_ff, found_in;
   logic                         created_ff, created_in;
   rlr_pkg::idx_type             slot_ff, slot_in;
   rlr_pkg::entry_type           ent_ff, ent_in;

   // result register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [2:0]                     rsp_status_ff, rsp_status_in;
   logic [rlr_pkg::DEPTH_W-1:0]    rsp_depth_ff, rsp_depth_in;
   logic [rlr_pkg::SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;

   // memory port
   logic               ram_we;
   rlr_pkg::idx_type   ram_waddr;
   logic [ENT_W-1:0]   ram_wdata;
   rlr_pkg::idx_type   ram_raddr;
   logic [ENT_W-1:0]   ram_rdata;
   rlr_pkg::entry_type rd_ent;

   // probe decode
   logic accept;
   logic make;
   logic p_hit, p_empty, p_tomb, p_last, p_done;
   logic apply_go;
   logic req_ready_s;

   rlr_pkg::upd_in_type  upd_in;
   rlr_pkg::upd_out_type upd_out;

   rlr_ram #(
      .DEPTH (rlr_pkg::TABLE_ENTRIES),
      .WIDTH (ENT_W)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign upd_in = '{mode:    mode_ff,
                     tid:     tid_ff,
                     invalid: invalid_ff,
                     found:   found_ff,
                     created: created_ff,
                     slot:    slot_ff,
                     entry:   ent_ff};

   rlr_update u_update (
      .upd_in  (upd_in),
      .upd_out (upd_out)
   );

   // Probe decode: the read data always belongs to cur_ff while probing.
   always_comb begin
      rd_ent   = rlr_pkg::entry_type'(ram_rdata);
      accept   = req.valid && req_ready_s;
      make     = mode_ff inside {rlr_pkg::MODE_INIT, rlr_pkg::MODE_ENTER};
      p_hit    = rd_ent.key == key_ff;
      p_empty  = rd_ent.key == rlr_pkg::KEY_EMPTY;
      p_tomb   = rd_ent.key == rlr_pkg::KEY_TOMB;
      p_last   = cnt_ff == rlr_pkg::IDX_W'(rlr_pkg::TABLE_ENTRIES - 1);
      p_done   = p_hit || p_empty || p_last;
      // write-back only when the result register can take the beat
      apply_go = !rsp_valid_ff || rsp.ready;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rlr_pkg::ST_CLEAR: begin
            if (clr_cnt_ff == rlr_pkg::IDX_W'(rlr_pkg::TABLE_ENTRIES - 1)) begin
               state_in = rlr_pkg::ST_IDLE;
            end
         end
         rlr_pkg::ST_IDLE: begin
            if (accept) begin
               // reserved keys skip the probe
               state_in = (req.lock_key == rlr_pkg::KEY_EMPTY ||
                           req.lock_key == rlr_pkg::KEY_TOMB) ?
                          rlr_pkg::ST_APPLY : rlr_pkg::ST_ISSUE;
            end
         end
         rlr_pkg::ST_ISSUE: begin
            state_in = rlr_pkg::ST_PROBE;
         end
         rlr_pkg::ST_PROBE: begin
            if (p_done) begin
               state_in = rlr_pkg::ST_APPLY;
            end
         end
         rlr_pkg::ST_APPLY: begin
            if (apply_go) begin
               state_in = rlr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rlr_pkg::ST_CLEAR;
         end
      endcase
   end

   // Outputs of the sequencer: memory port and request ready.
   always_comb begin
      req_ready_s = 1'b0;
      ram_we      = 1'b0;
      ram_waddr   = slot_ff;
      ram_wdata   = upd_out.entry;
      ram_raddr   = cur_ff;
      case (state_ff)
         rlr_pkg::ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_ff;
            ram_wdata = '0;
         end
         rlr_pkg::ST_IDLE: begin
            req_ready_s = 1'b1;
         end
         rlr_pkg::ST_ISSUE: begin
            ram_raddr = cur_ff;
         end
         rlr_pkg::ST_PROBE: begin
            // advance the read to the next slot; wraps by overflow
            ram_raddr = cur_ff + rlr_pkg::IDX_W'(1);
         end
         rlr_pkg::ST_APPLY: begin
            ram_we = apply_go && upd_out.we;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   assign req.ready = req_ready_s;

   // Datapath next values.
   always_comb begin
      clr_cnt_in    = clr_cnt_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      tid_in        = tid_ff;
      invalid_in    = invalid_ff;
      cur_in        = cur_ff;
      cnt_in        = cnt_ff;
      tomb_vld_in   = tomb_vld_ff;
      tomb_slot_in  = tomb_slot_ff;
      found_in      = found_ff;
      created_in    = created_ff;
      slot_in       = slot_ff;
      ent_in        = ent_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_depth_in  = rsp_depth_ff;
      rsp_slot_in   = rsp_slot_ff;

      if (state_ff == rlr_pkg::ST_CLEAR) begin
         clr_cnt_in = clr_cnt_ff + rlr_pkg::IDX_W'(1);
      end

      if (accept) begin
         mode_in     = rlr_pkg::mode_type'(req.mode);
         key_in      = req.lock_key;
         tid_in      = req.thread_id;
         invalid_in  = req.lock_key == rlr_pkg::KEY_EMPTY ||
                       req.lock_key == rlr_pkg::KEY_TOMB;
         cur_in      = rlr_pkg::home_slot(req.lock_key);
         cnt_in      = '0;
         tomb_vld_in = 1'b0;
         found_in    = 1'b0;
         created_in  = 1'b0;
      end

      if (state_ff == rlr_pkg::ST_PROBE) begin
         if (p_hit) begin
            found_in   = 1'b1;
            created_in = 1'b0;
            slot_in    = cur_ff;
            ent_in     = rd_ent;
         end else if (p_empty) begin
            // new entry goes to the first tombstone passed, else here
            found_in   = make;
            created_in = make;
            slot_in    = tomb_vld_ff ? tomb_slot_ff : cur_ff;
            ent_in     = '{key: key_ff, held: 1'b0, owner: '0, depth: '0};
         end else if (p_last) begin
            found_in   = 1'b0;
            created_in = 1'b0;
         end else begin
            if (p_tomb && !tomb_vld_ff) begin
               tomb_vld_in  = 1'b1;
               tomb_slot_in = cur_ff;
            end
            cur_in = cur_ff + rlr_pkg::IDX_W'(1);
            cnt_in = cnt_ff + rlr_pkg::IDX_W'(1);
         end
      end

      if (state_ff == rlr_pkg::ST_APPLY && apply_go) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = upd_out.status;
         rsp_depth_in  = upd_out.depth;
         rsp_slot_in   = upd_out.slot_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rlr_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      tid_ff        <= tid_in;
      invalid_ff    <= invalid_in;
      cur_ff        <= cur_in;
      cnt_ff        <= cnt_in;
      tomb_vld_ff   <= tomb_vld_in;
      tomb_slot_ff  <= tomb_slot_in;
      found_ff      <= found_in;
      created_ff    <= created_in;
      slot_ff       <= slot_in;
      ent_ff        <= ent_in;
      rsp_status_ff <= rsp_status_in;
      rsp_depth_ff  <= rsp_depth_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = rsp_status_ff;
   assign rsp.nesting_depth = rsp_depth_ff;
   assign rsp.slot_index    = rsp_slot_ff;

   // hold the write-back while the previous result is still stalled
   a_no_write_on_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rlr_pkg::ST_APPLY && rsp_valid_ff && !rsp.ready) |-> !ram_we)
      else $error("slot written while result register stalled");

   a_accept_starts_item: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == rlr_pkg::ST_ISSUE || state_ff == rlr_pkg::ST_APPLY))
      else $error("accepted item did not start");

   a_probe_advances: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rlr_pkg::ST_PROBE && !p_done) |=>
         (state_ff == rlr_pkg::ST_PROBE &&
          cur_ff == rlr_pkg::IDX_W'($past(cur_ff) + rlr_pkg::IDX_W'(1))))
      else $error("probe did not advance by one slot");

   a_invalid_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status == rlr_pkg::STAT_INVALID) |->
         (rsp.slot_index == '0 && rsp.nesting_depth == '0))
      else $error("reserved key reported a slot or depth");

endmodule
